[rtl/core/audio_gain_with_fade_out_defines.svh]
// Assertion macros for the audio gain block with fade-out.
// Included by the top level; depends on nothing else.
`ifndef AUDIO_GAIN_WITH_FADE_OUT_DEFINES_SVH
`define AUDIO_GAIN_WITH_FADE_OUT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GFO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gfo_pkg.sv]
// Shared types and constants of the audio gain block with fade-out.
// Used by the channel interfaces and by every RTL module; depends on nothing.
package gfo_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int VOL_BITS       = 7;
    localparam int RATE_BITS      = 18;
    localparam int LEN_BITS       = 24;
    localparam int SCALE_BITS     = 9;
    localparam int FADE_BITS      = 11;
    localparam int FPROD_BITS     = SAMPLE_BITS + FADE_BITS;
    localparam int GAIN_SHIFT     = 8;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLUME = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = CFG_INDEX_BITS'(3);

    localparam int FULL_VOLUME    = 100;

    // floor(v * 256 / 100) == (v * 10486) >> 12 for every 7-bit v.
    localparam int SCALE_RECIP    = 10486;
    localparam int SCALE_SHIFT    = 12;
    // floor(r / 200) == ((r >> 3) * 41944) >> 20 for every 18-bit r.
    localparam int FADE_PRESHIFT  = 3;
    localparam int FADE_RECIP     = 41944;
    localparam int FADE_SHIFT     = 20;

    localparam int VOLUME_RESET   = 80;
    localparam int RATE_RESET     = 44100;
    localparam int SCALE_RESET    = (VOLUME_RESET * 256) / 100;
    localparam int FADE_RESET     = (RATE_RESET * 5) / 1000;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = 1;
    localparam int QCNT_BITS      = 2;

    localparam int DIV_STEPS      = 16;
    localparam int DIV_CNT_BITS   = 4;

    typedef struct packed {
        logic [VOL_BITS-1:0]   volume;
        logic [SCALE_BITS-1:0] scale;
        logic [FADE_BITS-1:0]  fade_len;
        logic [LEN_BITS-1:0]   sound_len;
        logic                  mode;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic                          mute;
        logic                          scale;
        logic                          fade;
        logic [FADE_BITS-1:0]          samples_left;
    } t_job;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } t_queue_status;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_FADE_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

    function automatic logic [SCALE_BITS-1:0] scale_of(input logic [VOL_BITS-1:0] vol);
        logic [VOL_BITS+14-1:0] prod;
        prod = (VOL_BITS+14)'(vol) * (VOL_BITS+14)'(SCALE_RECIP);
        return SCALE_BITS'(prod >> SCALE_SHIFT);
    endfunction

    function automatic logic [FADE_BITS-1:0] fade_of(input logic [RATE_BITS-1:0] rate);
        logic [31:0] prod;
        prod = 32'(rate >> FADE_PRESHIFT) * 32'(FADE_RECIP);
        return FADE_BITS'(prod >> FADE_SHIFT);
    endfunction

endpackage

[rtl/core/gfo_if.sv]
// Channel interfaces of the audio gain block: sample input, sample output
// and configuration writes. Depends on gfo_pkg for the field widths.
interface gfo_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gfo_pkg::SAMPLE_BITS-1:0] in_sample;
    logic                                   first_of_sound;

    modport source (output valid, output in_sample, output first_of_sound, input ready);
    modport sink   (input valid, input in_sample, input first_of_sound, output ready);
endinterface

interface gfo_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gfo_pkg::SAMPLE_BITS-1:0] out_sample;
    logic                                   end_of_sound;

    modport source (output valid, output out_sample, output end_of_sound, input ready);
    modport sink   (input valid, input out_sample, input end_of_sound, output ready);
endinterface

interface gfo_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [gfo_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [gfo_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/audio_gain_with_fade_out.sv]
// Each accepted sample goes through the queue, the gain state of the back end and,
// when it fades, the fade multiply and the 16-step restoring divider by the fade
// length. The back end starts a new request only after its last result is loaded out.
// Reset is synchronous and active low: registers return to 80 percent volume,
// 44100 Hz, empty sound and mode set; the sample index clears to zero.
module audio_gain_with_fade_out #(
    parameter int INDEX_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gfo_in_if.sink     i_in,
    gfo_cfg_if.sink    i_cfg,
    gfo_out_if.source  o_out
);

`include "audio_gain_with_fade_out_defines.svh"

    // Configuration registers. The scale factor and the fade length are derived
    // when their source register is written, so their divisions need no divider on the sample path.
    gfo_pkg::t_cfg          r_cfg;

    // Handshake between the front end, the queue and the back end.
    logic                   w_push;
    gfo_pkg::t_job          w_push_job;
    gfo_pkg::t_job          w_pop_job;
    gfo_pkg::t_queue_status w_qstat;
    gfo_pkg::t_back_status  w_bstat;

    assign i_cfg.ready = 1'b1;

    // A write to an index past the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume    <= gfo_pkg::VOL_BITS'(gfo_pkg::VOLUME_RESET);
            r_cfg.scale     <= gfo_pkg::SCALE_BITS'(gfo_pkg::SCALE_RESET);
            r_cfg.fade_len  <= gfo_pkg::FADE_BITS'(gfo_pkg::FADE_RESET);
            r_cfg.sound_len <= '0;
            r_cfg.mode      <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                gfo_pkg::CFG_VOLUME: begin
                    r_cfg.volume <= i_cfg.data[gfo_pkg::VOL_BITS-1:0];
                    r_cfg.scale  <= gfo_pkg::scale_of(i_cfg.data[gfo_pkg::VOL_BITS-1:0]);
                end
                gfo_pkg::CFG_RATE: begin
                    r_cfg.fade_len <= gfo_pkg::fade_of(i_cfg.data[gfo_pkg::RATE_BITS-1:0]);
                end
                gfo_pkg::CFG_LENGTH: begin
                    r_cfg.sound_len <= i_cfg.data[gfo_pkg::LEN_BITS-1:0];
                end
                gfo_pkg::CFG_MODE: begin
                    r_cfg.mode <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end tracks the sample index and decides per sample whether it
    // is muted, scaled and faded, so the back end only does arithmetic.
    gfo_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (w_qstat.full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    // The queue lets the front end keep taking samples while the divider runs.
    gfo_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_bstat.pop),
        .o_pop_job  (w_pop_job),
        .o_status   (w_qstat)
    );

    // The back end owns the output register, so a finished result waiting on
    // the consumer does not stop the next request from starting.
    gfo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (w_qstat),
        .i_job    (w_pop_job),
        .o_status (w_bstat),
        .o_out    (o_out)
    );

    `GFO_ASSERT_IMPLY(a_queue_bound, i_clk, i_rst_n, 1'b1, w_qstat.count <= gfo_pkg::QCNT_BITS'(gfo_pkg::QUEUE_DEPTH), "queue holds more requests than its depth")
    `GFO_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, w_bstat.pop, !w_qstat.empty, "back end popped an empty queue")
    `GFO_ASSERT_IMPLY(a_full_stalls, i_clk, i_rst_n, w_qstat.full, !i_in.ready, "input ready while the queue is full")
    `GFO_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, w_bstat.pop, w_bstat.busy, "popped request did not start in the back end")

endmodule

[rtl/core/gfo_front.sv]
// Front end: accepts samples, keeps the sample index and classifies each request.
// Depends on gfo_pkg and gfo_in_if.
module gfo_front #(
    parameter int INDEX_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gfo_in_if.sink         i_in,
    input  gfo_pkg::t_cfg  i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output gfo_pkg::t_job  o_job
);

    localparam int CW = (INDEX_BITS > gfo_pkg::LEN_BITS) ? INDEX_BITS : gfo_pkg::LEN_BITS;

    logic [INDEX_BITS-1:0] r_sample_index;
    logic [INDEX_BITS-1:0] n_sample_index;
    logic [INDEX_BITS-1:0] w_idx;
    logic [CW-1:0]         w_idx_x;
    logic [CW-1:0]         w_tot_x;
    logic [CW-1:0]         w_fade_x;
    logic [CW-1:0]         w_samples_left;
    logic                  w_active;

    always_comb begin
        w_idx          = i_in.first_of_sound ? '0 : r_sample_index;
        w_idx_x        = CW'(w_idx);
        w_tot_x        = CW'(i_cfg.sound_len);
        w_fade_x       = CW'(i_cfg.fade_len);
        w_samples_left = w_tot_x - w_idx_x - CW'(1);
        w_active       = i_cfg.mode && (i_cfg.volume != '0);

        o_job.sample       = i_in.in_sample;
        o_job.last         = (w_tot_x != '0) && (w_idx_x == w_tot_x - CW'(1));
        o_job.mute         = i_cfg.mode && (i_cfg.volume == '0);
        o_job.scale        = w_active
                             && (i_cfg.volume < gfo_pkg::VOL_BITS'(gfo_pkg::FULL_VOLUME));
        o_job.fade         = w_active && (w_fade_x != '0) && (w_fade_x <= w_tot_x)
                             && (w_idx_x < w_tot_x) && (w_samples_left < w_fade_x);
        o_job.samples_left = gfo_pkg::FADE_BITS'(w_samples_left);

        // The index saturates at its largest value.
        n_sample_index = (w_idx != '1) ? w_idx + 1'b1 : w_idx;

        i_in.ready = !i_q_full;
        o_push     = i_in.valid && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
        end else if (o_push) begin
            r_sample_index <= n_sample_index;
        end
    end

endmodule

[rtl/core/gfo_queue.sv]
// Short request queue between the front end and the back end.
// Depends on gfo_pkg for the request type and the depth.
module gfo_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  gfo_pkg::t_job          i_push_job,
    input  logic                   i_pop,
    output gfo_pkg::t_job          o_pop_job,
    output gfo_pkg::t_queue_status o_status
);

    gfo_pkg::t_job                    r_mem [gfo_pkg::QUEUE_DEPTH];
    logic [gfo_pkg::QPTR_BITS-1:0]    r_wr_ptr;
    logic [gfo_pkg::QPTR_BITS-1:0]    r_rd_ptr;
    logic [gfo_pkg::QCNT_BITS-1:0]    r_count;

    always_comb begin
        o_pop_job      = r_mem[r_rd_ptr];
        o_status.count = r_count;
        o_status.empty = (r_count == '0);
        o_status.full  = (r_count == gfo_pkg::QCNT_BITS'(gfo_pkg::QUEUE_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/gfo_back.sv]
// Back end: volume multiply, fade multiply, 16-step divider and output register.
// Depends on gfo_pkg and gfo_out_if.
module gfo_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gfo_pkg::t_cfg          i_cfg,
    input  gfo_pkg::t_queue_status i_qstat,
    input  gfo_pkg::t_job          i_job,
    output gfo_pkg::t_back_status  o_status,
    gfo_out_if.source              o_out
);

    localparam int SB = gfo_pkg::SAMPLE_BITS;
    localparam int FB = gfo_pkg::FADE_BITS;
    localparam int GB = SB + gfo_pkg::SCALE_BITS + 1;

    gfo_pkg::t_back_state          r_state;
    gfo_pkg::t_back_state          n_state;
    gfo_pkg::t_job                 r_job;
    logic signed [SB-1:0]          r_s;
    logic [FB-1:0]                 r_rem;
    logic [SB-1:0]                 r_dq;
    logic                          r_neg;
    logic [gfo_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic                          r_out_valid;
    logic signed [SB-1:0]          r_out_sample;
    logic                          r_out_last;

    logic                          w_pop;
    logic                          w_load_out;
    logic signed [GB-1:0]          w_gain_prod;
    logic signed [SB-1:0]          w_gain_s;
    logic [SB-1:0]                 w_mag;
    logic [gfo_pkg::FPROD_BITS-1:0] w_fprod;
    logic [FB:0]                   w_trial;
    logic                          w_ge;
    logic [FB-1:0]                 w_rem_next;
    logic signed [SB-1:0]          w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            gfo_pkg::ST_IDLE: begin
                if (!i_qstat.empty) begin
                    w_pop   = 1'b1;
                    n_state = gfo_pkg::ST_GAIN;
                end
            end
            gfo_pkg::ST_GAIN: begin
                n_state = r_job.fade ? gfo_pkg::ST_FADE_MUL : gfo_pkg::ST_DONE;
            end
            gfo_pkg::ST_FADE_MUL: begin
                n_state = gfo_pkg::ST_DIV;
            end
            gfo_pkg::ST_DIV: begin
                if (r_cnt == gfo_pkg::DIV_CNT_BITS'(gfo_pkg::DIV_STEPS - 1)) begin
                    n_state = gfo_pkg::ST_DONE;
                end
            end
            gfo_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = gfo_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gfo_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_gain_prod = GB'(r_s) * $signed({1'b0, i_cfg.scale});
        w_gain_s    = SB'(w_gain_prod >>> gfo_pkg::GAIN_SHIFT);
        w_mag       = r_s[SB-1] ? SB'(-r_s) : SB'(r_s);
        w_fprod     = gfo_pkg::FPROD_BITS'(w_mag) * gfo_pkg::FPROD_BITS'(r_job.samples_left);
        w_trial     = {r_rem, r_dq[SB-1]};
        w_ge        = (w_trial >= {1'b0, i_cfg.fade_len});
        w_rem_next  = w_ge ? FB'(w_trial - {1'b0, i_cfg.fade_len}) : w_trial[FB-1:0];
        if (r_job.fade) begin
            w_result = r_neg ? -$signed(r_dq) : $signed(r_dq);
        end else begin
            w_result = r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gfo_pkg::ST_IDLE: begin
                if (w_pop) begin
                    r_job <= i_job;
                    r_s   <= i_job.sample;
                end
            end
            gfo_pkg::ST_GAIN: begin
                if (r_job.mute) begin
                    r_s <= '0;
                end else if (r_job.scale) begin
                    r_s <= w_gain_s;
                end
            end
            gfo_pkg::ST_FADE_MUL: begin
                r_neg <= r_s[SB-1];
                r_rem <= w_fprod[gfo_pkg::FPROD_BITS-1:SB];
                r_dq  <= w_fprod[SB-1:0];
                r_cnt <= '0;
            end
            gfo_pkg::ST_DIV: begin
                r_rem <= w_rem_next;
                r_dq  <= {r_dq[SB-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= w_result;
            r_out_last   <= r_job.last;
        end
    end

    always_comb begin
        o_out.valid        = r_out_valid;
        o_out.out_sample   = r_out_sample;
        o_out.end_of_sound = r_out_last;
        o_status.pop       = w_pop;
        o_status.busy      = (r_state != gfo_pkg::ST_IDLE);
    end

endmodule
